// ----- hw/rtl/kfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfs_pkg - shared types and constants of the per-element Kalman smoother
// Fixed-point formats, register indexes and the structs that travel between
// the controller, the state memory and the gain divider.
// ----------------------------------------------------------------------------
package kfs_pkg;

  localparam int unsigned MaxElements = 32768;
  localparam int unsigned AddrW       = $clog2(MaxElements);

  localparam int unsigned SampleW = 16;  // Q7.8 estimate / sample
  localparam int unsigned VarW    = 17;  // Q1.16 stored variance
  localparam int unsigned PredW   = 18;  // P + Q, and P + Q + R
  localparam int unsigned GainW   = 17;  // Q0.16 gain, 1.0 included
  localparam int unsigned RegW    = 16;  // configuration register width
  localparam int unsigned RegIdxW = 2;

  localparam logic [GainW-1:0] OneQ16  = GainW'(65536);
  localparam logic [VarW-1:0]  OneVar  = VarW'(65536);
  localparam logic [VarW-1:0]  VarMax  = VarW'(131071);

  localparam logic [RegW-1:0] VlenReset   = RegW'(32768);
  localparam logic [RegW-1:0] QNoiseReset = RegW'(655);
  localparam logic [RegW-1:0] RNoiseReset = RegW'(6554);

  typedef enum logic [RegIdxW-1:0] {
    REG_VLEN   = 2'd0,
    REG_QNOISE = 2'd1,
    REG_RNOISE = 2'd2
  } kfs_reg_e;

  // One write into both state memories.
  typedef struct packed {
    logic                     en;
    logic [AddrW-1:0]         addr;
    logic [SampleW-1:0]       est;
    logic [VarW-1:0]          var_q16;
  } kfs_wr_t;

  // Start of one gain division K = p * 2^16 / den.
  typedef struct packed {
    logic             start;
    logic [PredW-1:0] num;
    logic [PredW-1:0] den;
  } kfs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [GainW-1:0] quot;
  } kfs_div_rsp_t;

endpackage

// ----- hw/rtl/kfs_state_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfs_state_mem - per-element estimate and variance storage
// Two synchronous single-port-write, single-read memories with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module kfs_state_mem
  import kfs_pkg::*;
(
  input  logic               clk_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output logic [SampleW-1:0] rd_est_o,
  output logic [VarW-1:0]    rd_var_o,
  input  kfs_wr_t            wr_i
);

  logic [SampleW-1:0] est_mem [MaxElements];
  logic [VarW-1:0]    var_mem [MaxElements];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      est_mem[wr_i.addr] <= wr_i.est;
      var_mem[wr_i.addr] <= wr_i.var_q16;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_est_o <= est_mem[rd_addr_i];
    rd_var_o <= var_mem[rd_addr_i];
  end

endmodule

// ----- hw/rtl/kfs_gain_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfs_gain_div - iterative restoring divider for the Kalman gain
// Produces floor(num * 2^16 / den), one quotient bit per cycle, 17 steps.
// A zero denominator returns 1.0 on the next cycle.
// ----------------------------------------------------------------------------
module kfs_gain_div
  import kfs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kfs_div_req_t req_i,
  output kfs_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(GainW + 1);
  localparam logic [CntW-1:0] StepsTotal = CntW'(GainW);

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic               done_q;
  logic [PredW-1:0]   rem_q, rem_d;
  logic [PredW-1:0]   den_q;
  logic [GainW-1:0]   quot_q;
  logic [PredW:0]     shifted;
  logic               ge;

  // First step compares num itself, later steps the doubled remainder.
  always_comb begin
    shifted = (cnt_q == StepsTotal) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? PredW'(shifted - {1'b0, den_q}) : shifted[PredW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (req_i.start && (req_i.den == '0)) begin
        done_q <= 1'b1;
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= StepsTotal;
        done_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q - CntW'(1);
        busy_q <= (cnt_q != CntW'(1));
        done_q <= (cnt_q == CntW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && (req_i.den == '0)) begin
      quot_q <= OneQ16;
    end else if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[GainW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  // A new division never lands on one still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("gain divider restarted while busy");

  // Completion is flagged in the cycle after the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == CntW'(1)) |=> done_q && !busy_q)
    else $error("gain divider missed its completion");

endmodule

// ----- hw/rtl/per_element_kalman_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_element_kalman_smoother - scalar Kalman filter per vector element
//
// Usage:
//   Samples (signed Q7.8) enter one beat at a time on the s_axis channel.
//   A position counter groups them into vectors of vector_length elements;
//   each position owns a Kalman filter whose estimate and variance sit in
//   on-chip memory. Every input beat yields exactly one output beat on the
//   m_axis channel: the filtered estimate, tlast on the last element of a
//   vector, tuser set while the initializing vector passes unchanged.
//   Path: an initializing (passthrough) element goes from acceptance
//   straight to write-back and the output register; a filtered one passes
//   the memory read, the 17-step gain divider, multiply and write-back steps.
//   One item at a time: no new sample is taken until the last is written back.
//   Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i write a register on
//   the clock edge; write only while the block is idle. Writing
//   vector_length restarts the passthrough vector; noise writes do not.
//   Reset: control state clears, the next vector passes through and
//   initializes memory. No clearing sweep is run: memory contents are
//   undefined until that first vector writes them.
//   Stall: a finished result holds in the output register; the next sample
//   is still accepted and processed, and its write-back waits for the slot.
// ----------------------------------------------------------------------------
module per_element_kalman_smoother
  import kfs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [RegIdxW-1:0]   cfg_idx_i,
  input  logic [RegW-1:0]      cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SampleW-1:0]   s_axis_tdata,   // [15:0] sample_value
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SampleW-1:0]   m_axis_tdata,   // [15:0] smoothed_value
  output logic                 m_axis_tlast,   // vector_end
  output logic                 m_axis_tuser    // [0] passthrough
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_WB   = 5'b10000
  } kfs_state_e;

  localparam int unsigned ProdW = 35;  // K*d signed, (1-K)*p unsigned

  kfs_state_e state_q, state_d;

  // Configuration registers
  logic [RegW-1:0] vlen_q, qnoise_q, rnoise_q;
  logic            primed_q;
  logic [AddrW-1:0] position_q;

  // Captured item
  logic [AddrW-1:0]   addr_q;
  logic [SampleW-1:0] z_q;
  logic               item_last_q, item_pass_q;

  // Datapath registers
  logic [SampleW-1:0]       x_q;
  logic [PredW-1:0]         p_q;
  logic signed [SampleW:0]  d_q;
  logic [GainW-1:0]         k_q;
  logic signed [ProdW-1:0]  prod_x_q;
  logic [ProdW-1:0]         prod_p_q;

  // Output register
  logic               out_valid_q;
  logic [SampleW-1:0] out_data_q;
  logic               out_last_q, out_pass_q;

  // Memory and divider links
  logic [SampleW-1:0] rd_est;
  logic [VarW-1:0]    rd_var;
  kfs_wr_t            wr;
  kfs_div_req_t       div_req;
  kfs_div_rsp_t       div_rsp;

  logic               in_fire, slot_free, wb_fire;
  logic [RegW-1:0]    len_eff;
  logic [AddrW-1:0]   pos_eff;
  logic               is_last;

  // ---------------------------------------------------------------------
  // Vector length and position: zero acts as one, oversize clamps.
  // ---------------------------------------------------------------------
  always_comb begin
    if (vlen_q == '0) begin
      len_eff = RegW'(1);
    end else if (vlen_q > RegW'(MaxElements)) begin
      len_eff = RegW'(MaxElements);
    end else begin
      len_eff = vlen_q;
    end
    pos_eff = ({1'b0, position_q} >= len_eff) ? '0 : position_q;
    is_last = ({1'b0, pos_eff} == (len_eff - RegW'(1)));
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign wb_fire       = (state_q == ST_WB) && slot_free;

  // ---------------------------------------------------------------------
  // Sequencer. A passthrough element skips straight to write-back.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = primed_q ? ST_READ : ST_WB;
        end
      end
      ST_READ: state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration, position counter and primed flag
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q     <= VlenReset;
      qnoise_q   <= QNoiseReset;
      rnoise_q   <= RNoiseReset;
      primed_q   <= 1'b0;
      position_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VLEN: begin
          vlen_q     <= cfg_wdata_i;
          primed_q   <= 1'b0;
          position_q <= '0;
        end
        REG_QNOISE: qnoise_q <= cfg_wdata_i;
        REG_RNOISE: rnoise_q <= cfg_wdata_i;
        default: ;  // unmapped index: drop the write
      endcase
    end else if (in_fire) begin
      if (is_last) begin
        position_q <= '0;
        primed_q   <= 1'b1;
      end else begin
        position_q <= AddrW'({1'b0, pos_eff} + 16'd1);
      end
    end
  end

  // Capture the accepted sample and its place in the vector.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q      <= pos_eff;
      z_q         <= s_axis_tdata;
      item_last_q <= is_last;
      item_pass_q <= !primed_q;
    end
  end

  // ---------------------------------------------------------------------
  // State memory. The read address is the live position, so the entry is
  // fetched at the accepting edge and shows up in ST_READ. Write-back
  // lands as the block returns to idle, so the next read of the same
  // entry always sees it: no forwarding path is needed.
  // ---------------------------------------------------------------------
  kfs_state_mem u_mem (
    .clk_i     (clk_i),
    .rd_addr_i (pos_eff),
    .rd_est_o  (rd_est),
    .rd_var_o  (rd_var),
    .wr_i      (wr)
  );

  // ---------------------------------------------------------------------
  // Predict: p = P + Q, den = p + R, innovation d = z - x. Start the gain.
  // ---------------------------------------------------------------------
  logic [PredW-1:0] p_pred;

  always_comb begin
    p_pred        = PredW'(rd_var) + PredW'(qnoise_q);
    div_req.start = (state_q == ST_READ);
    div_req.num   = p_pred;
    div_req.den   = p_pred + PredW'(rnoise_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      x_q <= rd_est;
      p_q <= p_pred;
      d_q <= $signed({z_q[SampleW-1], z_q}) - $signed({rd_est[SampleW-1], rd_est});
    end
  end

  kfs_gain_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Update products: K*d for the estimate, (1-K)*p for the variance.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV) && div_rsp.done) begin
      k_q <= div_rsp.quot;
    end
    if (state_q == ST_MUL) begin
      prod_x_q <= ProdW'($signed({1'b0, k_q}) * d_q);
      prod_p_q <= ProdW'((OneQ16 - k_q) * p_q);
    end
  end

  // ---------------------------------------------------------------------
  // Write-back: round half up, clamp variance, load output register.
  // The new estimate lies between x and z, so 16 bits always hold it.
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0] sum_x;
  logic signed [ProdW-1:0] step_x;
  logic [ProdW:0]          sum_p;
  logic [19:0]             pn_full;
  logic [VarW-1:0]         pn;
  logic [SampleW-1:0]      x_new;

  always_comb begin
    sum_x   = prod_x_q + ProdW'(32768);
    step_x  = sum_x >>> 16;
    x_new   = x_q + step_x[SampleW-1:0];
    sum_p   = {1'b0, prod_p_q} + (ProdW + 1)'(32768);
    pn_full = sum_p[35:16];
    pn      = (pn_full > 20'(VarMax)) ? VarMax : pn_full[VarW-1:0];

    wr.en      = wb_fire;
    wr.addr    = addr_q;
    wr.est     = item_pass_q ? z_q : x_new;
    wr.var_q16 = item_pass_q ? OneVar : pn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      out_data_q <= wr.est;
      out_last_q <= item_last_q;
      out_pass_q <= item_pass_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_pass_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // An accepted sample goes to the memory read, or straight to write-back
  // when it belongs to the initializing vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == ST_READ) == $past(primed_q)) &&
                ((state_q == ST_WB) == !$past(primed_q)))
    else $error("accepted sample took the wrong path");

  // Memory is written only from write-back, and only with a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ST_WB) && slot_free)
    else $error("state memory written outside write-back");

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("gain divider finished outside its wait state");

  // Every write-back produces a valid result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> out_valid_q && (state_q == ST_IDLE))
    else $error("write-back did not load the output register");

endmodule

// ----- tb/sv/per_element_kalman_smoother_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_element_kalman_smoother_tb - self-checking bench of the Kalman smoother
// Drives samples on the input stream and checks every output beat against
// a predictor that tracks the per-position estimate and variance stores.
// It covers directed edge cases first, then random vectors under several
// handshake pressure phases.
// ----------------------------------------------------------------------------
module per_element_kalman_smoother_tb;
  import kfs_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned ReportMax   = 10;

  // Index 3 decodes to no register; the block must ignore the write.
  localparam logic [RegIdxW-1:0] RegUnused = 2'd3;

  localparam logic [SampleW-1:0] SmpMaxPos = 16'h7FFF;
  localparam logic [SampleW-1:0] SmpMaxNeg = 16'h8000;
  localparam logic [SampleW-1:0] SmpZero   = 16'h0000;
  localparam logic [SampleW-1:0] SmpMinus1 = 16'hFFFF;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
    logic               pass;
  } smoothed_beat_t;

  // --------------------------------------------------------------------------
  // Predictor and pending-output store
  // --------------------------------------------------------------------------
  class smoother_scoreboard;
    logic [SampleW-1:0] est_mem [MaxElements];
    logic [VarW-1:0]    var_mem [MaxElements];
    bit                 primed;
    int unsigned        position;
    int unsigned        vlen;
    int unsigned        q_noise;
    int unsigned        r_noise;
    smoothed_beat_t     pending[$];
    int unsigned        fail_count;

    function new();
      primed     = 1'b0;
      position   = 0;
      vlen       = VlenReset;
      q_noise    = QNoiseReset;
      r_noise    = RNoiseReset;
      fail_count = 0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] val);
      case (idx)
        REG_VLEN: begin
          vlen     = val;
          primed   = 1'b0;
          position = 0;
        end
        REG_QNOISE: q_noise = val;
        REG_RNOISE: r_noise = val;
        default: ;
      endcase
    endfunction

    // Run one element through its filter and queue the beat it must produce.
    function void take_sample(logic [SampleW-1:0] raw);
      int unsigned    len;
      int unsigned    pos;
      int             zi;
      int             xi;
      longint         p;
      longint         den;
      longint         k;
      longint         d;
      longint         stepv;
      longint         pn;
      smoothed_beat_t beat;
      len = (vlen == 0) ? 1 : ((vlen > MaxElements) ? MaxElements : vlen);
      pos = (position >= len) ? 0 : position;
      zi  = $signed(raw);
      beat.last = (pos == len - 1);
      beat.pass = !primed;
      if (!primed) begin
        est_mem[pos] = raw;
        var_mem[pos] = OneVar;
        beat.value   = raw;
      end else begin
        xi  = $signed(est_mem[pos]);
        p   = var_mem[pos];
        p   = p + q_noise;
        den = p + r_noise;
        // all of P, Q and R zero: take the full gain
        k   = (den == 0) ? 65536 : ((p << 16) / den);
        d   = zi - xi;
        stepv = (k * d + 32768) >>> 16;
        pn  = ((65536 - k) * p + 32768) >>> 16;
        if (pn > VarMax) pn = VarMax;
        est_mem[pos] = SampleW'(xi + stepv);
        var_mem[pos] = VarW'(pn);
        beat.value   = est_mem[pos];
      end
      if (beat.last) begin
        position = 0;
        primed   = 1'b1;
      end else begin
        position = pos + 1;
      end
      pending.insert(pending.size(), beat);
    endfunction

    function void check_output(logic [SampleW-1:0] value, logic last, logic pass);
      smoothed_beat_t want;
      if (pending.size() == 0) begin
        if (fail_count < ReportMax)
          $display("unexpected output beat: value %h last %b pass %b", value, last, pass);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (want.value !== value || want.last !== last || want.pass !== pass) begin
        if (fail_count < ReportMax)
          $display({"output mismatch: expected value %h last %b pass %b, ",
                    "got value %h last %b pass %b"},
                   want.value, want.last, want.pass, value, last, pass);
        fail_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [RegIdxW-1:0] cfg_idx       = '0;
  logic [RegW-1:0]    cfg_wdata     = '0;
  logic               s_tvalid      = 1'b0;
  logic [SampleW-1:0] s_tdata       = '0;
  logic               s_axis_tready;
  logic               m_axis_tvalid;
  logic               m_tready      = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  int unsigned        src_idle_pct  = 0;
  int unsigned        snk_stall_pct = 0;
  int unsigned        cycle_count   = 0;

  smoother_scoreboard sb;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  per_element_kalman_smoother u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Receiver: stall at random on the falling edge, per the current phase.
  always @(negedge clk_i) begin
    m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Monitor: everything is sampled on the rising edge, before the block's
  // registers move. Check the output beat before noting a new sample; the
  // output always belongs to an older beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready)
        sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (s_tvalid && s_axis_tready)
        sb.take_sample(s_tdata);
      if (cfg_we)
        sb.write_reg(cfg_idx, cfg_wdata);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("per_element_kalman_smoother_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers; each is entered and left on a falling edge
  // --------------------------------------------------------------------------

  // Offer one sample, idling first at random; hold it until the beat goes.
  task automatic push_sample(input logic [SampleW-1:0] z);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = z;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // Drop valid, wait for every pending beat, then let the pipeline settle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Noise values lean on the extremes now and then.
  function automatic logic [RegW-1:0] pick_noise();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return RegW'($urandom_range(0, 1023));
    return RegW'($urandom_range(0, 65535));
  endfunction

  // One random phase. With restart set the vector length is rewritten and
  // a new passthrough vector starts; otherwise only the noise moves, possibly
  // in the middle of a vector.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input bit restart, input int unsigned n_items);
    int unsigned       sel;
    logic [RegW-1:0]   len;
    logic [SampleW-1:0] z;
    drain();
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (restart) begin
      sel = $urandom_range(0, 7);
      if (sel == 0)      len = '0;
      else if (sel == 1) len = RegW'($urandom_range(25, 80));
      else               len = RegW'($urandom_range(1, 16));
      write_cfg(REG_VLEN, len);
    end
    write_cfg(REG_QNOISE, pick_noise());
    write_cfg(REG_RNOISE, pick_noise());
    repeat (n_items) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0:       z = SmpMaxPos;
        1:       z = SmpMaxNeg;
        2:       z = SmpZero;
        3:       z = SmpMinus1;
        default: z = SampleW'($urandom_range(0, 65535));
      endcase
      push_sample(z);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Short vectors at reset noise: full-scale swings through the filter.
    write_cfg(REG_VLEN, 16'd4);
    push_sample(SmpMaxPos);
    push_sample(SmpMaxNeg);
    push_sample(SmpZero);
    push_sample(SmpMinus1);
    push_sample(SmpMaxNeg);
    push_sample(SmpMaxPos);
    push_sample(16'h0001);
    push_sample(SmpMinus1);
    // A write to the unused index must leave everything as it was.
    drain();
    write_cfg(RegUnused, 16'hFFFF);
    push_sample(16'h0100);
    push_sample(16'hFF00);
    push_sample(SmpMaxPos);
    push_sample(SmpMaxNeg);

    // Zero vector length behaves as one element per vector.
    drain();
    write_cfg(REG_VLEN, 16'd0);
    push_sample(16'h4000);
    push_sample(16'hC000);
    push_sample(SmpMaxPos);

    // Zero Q and R: the first filtered pass drives P to zero, the next one
    // hits a zero gain denominator and must take the sample as is.
    drain();
    write_cfg(REG_QNOISE, 16'd0);
    write_cfg(REG_RNOISE, 16'd0);
    write_cfg(REG_VLEN, 16'd2);
    push_sample(16'h0100);
    push_sample(SmpMaxNeg);
    push_sample(SmpMaxPos);
    push_sample(SmpZero);
    push_sample(16'h1234);
    push_sample(SmpMaxNeg);

    // Largest noise values.
    drain();
    write_cfg(REG_QNOISE, 16'hFFFF);
    write_cfg(REG_RNOISE, 16'hFFFF);
    write_cfg(REG_VLEN, 16'd1);
    push_sample(SmpMaxNeg);
    push_sample(SmpMaxPos);
    push_sample(SmpMaxNeg);
    push_sample(SmpMaxPos);

    // Oversized and maximum lengths: only a slice of the passthrough vector.
    drain();
    write_cfg(REG_VLEN, 16'hFFFF);
    repeat (12) push_sample(SampleW'($urandom_range(0, 65535)));
    drain();
    write_cfg(REG_VLEN, 16'h8000);
    repeat (6) push_sample(SampleW'($urandom_range(0, 65535)));

    // Random part: every pressure mode, each with a fresh vector length and
    // then a noise change on the running vectors.
    run_phase(0, 0, 1'b1, 135);
    run_phase(0, 0, 1'b0, 135);
    run_phase(45, 0, 1'b1, 135);
    run_phase(45, 0, 1'b0, 135);
    run_phase(0, 45, 1'b1, 135);
    run_phase(0, 45, 1'b0, 135);
    run_phase(8, 8, 1'b1, 135);
    run_phase(8, 8, 1'b0, 135);

    drain();
    if (sb.pending.size() != 0) sb.fail_count++;
    if (sb.fail_count == 0) begin
      $display("per_element_kalman_smoother_tb passed");
    end else begin
      $display("per_element_kalman_smoother_tb failed");
    end
    $finish;
  end

endmodule
